>>> hdl/frt_pkg.sv
`default_nettype none
package frt_pkg;

  typedef enum logic [3:0] {
    ST_ACCEPTED  = 4'd0,
    ST_DUPLICATE = 4'd1,
    ST_COMPLETED = 4'd2,
    ST_BAD_LEN   = 4'd3,
    ST_OOB       = 4'd4,
    ST_SHORT     = 4'd5,
    ST_UNKNOWN   = 4'd6,
    ST_BAD_INDEX = 4'd7,
    ST_FULL      = 4'd8,
    ST_TICK_DONE = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_TICK,
    S_OUT
  } state_e;

  localparam logic [1:0] REG_MAX_BYTES = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;

  localparam logic [23:0] MAX_BYTES_RST = 24'd65536;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2000;

endpackage
`default_nettype wire

>>> hdl/fragment_reassembly_tracker.sv
// Fragment reassembly tracker. Each word on the input channel is a fragment
// header or a time tick, and produces exactly one result word. A single
// sequencer walks the table one slot per cycle through a shared key compare /
// age increment unit: a fragment scans all slots, a tick ages them. The input
// is stalled while an item is in work or its result has not been taken.
// Checks that need no table (bad length, out of bounds, short payload,
// unknown client) skip the walk. Table fields other than the valid bits hold
// no reset value; an entry is fully written when it is made. Registers: 0
// max_packet_bytes, 1 timeout_ticks, written over the APB-style port; the user
// must write them only while the block is idle, which it does not enforce.
`default_nettype none
module fragment_reassembly_tracker #(
  parameter int ENTRIES   = 16,
  parameter int MAX_FRAGS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] src_id_i,
  input  wire logic [31:0] pkt_seqno_i,
  input  wire logic [31:0] total_len_i,
  input  wire logic [31:0] byte_offset_i,
  input  wire logic [15:0] frag_len_i,
  input  wire logic [15:0] present_len_i,
  input  wire logic [15:0] piece_count_i,
  input  wire logic [15:0] piece_idx_i,
  input  wire logic [63:0] pts_i,
  input  wire logic        client_known_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       status_o,
  output logic [3:0]       entry_slot_o,
  output logic [23:0]      write_offset_o,
  output logic [15:0]      write_len_o,
  output logic [23:0]      packet_len_o,
  output logic [63:0]      packet_pts_o,
  output logic [4:0]       expired_count_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int FW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam logic [SW-1:0] LAST = SW'(ENTRIES - 1);

  frt_pkg::state_e state_q, state_d;

  logic [23:0] max_bytes_q;
  logic [15:0] timeout_q;

  // table
  logic [ENTRIES-1:0]   valid_q;
  logic [31:0]          e_client_q [ENTRIES];
  logic [31:0]          e_seq_q    [ENTRIES];
  logic [23:0]          e_total_q  [ENTRIES];
  logic [15:0]          e_nfrag_q  [ENTRIES];
  logic [31:0]          e_bytes_q  [ENTRIES];
  logic [63:0]          e_stamp_q  [ENTRIES];
  logic [15:0]          e_age_q    [ENTRIES];
  logic [MAX_FRAGS-1:0] e_seen_q   [ENTRIES];

  // captured word
  logic        op_q;
  logic [31:0] cl_q, sq_q;
  logic [23:0] tot_q;
  logic [23:0] off_q;
  logic [15:0] flen_q, nf_q, idx_q;
  logic [63:0] pts_q;
  logic        early_q;
  logic [32:0] end_q;

  logic [SW-1:0] ptr_q;
  logic          hit_q, free_q;
  logic [SW-1:0] hit_slot_q, free_slot_q;
  logic [CW-1:0] exp_q;
  logic [SW-1:0] slot_q;

  logic [3:0]  r_status_q, r_status_d;
  logic [23:0] r_off_q;
  logic [15:0] r_len_q;
  logic [23:0] r_plen_q;
  logic [63:0] r_pts_q;

  logic accept, cfg_wr;
  logic [32:0] end_in;
  logic [3:0]  early_status;
  logic        key_eq;
  logic [16:0] age_inc;
  logic        idx_bad, seen_bit, complete;
  logic [31:0] bytes_new;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != frt_pkg::S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      frt_pkg::REG_MAX_BYTES[0]: prdata = {8'd0, max_bytes_q};
      default:                   prdata = {16'd0, timeout_q};
    endcase
  end

  assign end_in = {1'b0, byte_offset_i} + 33'(frag_len_i);

  always_comb begin
    if (total_len_i == 32'd0 || total_len_i > {8'd0, max_bytes_q}) begin
      early_status = frt_pkg::ST_BAD_LEN;
    end else if (end_in > {1'b0, total_len_i}) begin
      early_status = frt_pkg::ST_OOB;
    end else if (present_len_i < frag_len_i) begin
      early_status = frt_pkg::ST_SHORT;
    end else if (!client_known_i) begin
      early_status = frt_pkg::ST_UNKNOWN;
    end else begin
      early_status = frt_pkg::ST_ACCEPTED;
    end
  end

  // shared per-slot unit
  assign key_eq  = (e_client_q[ptr_q] == cl_q) && (e_seq_q[ptr_q] == sq_q);
  assign age_inc = {1'b0, e_age_q[ptr_q]} + 17'd1;

  assign idx_bad   = (idx_q >= e_nfrag_q[slot_q]) || (32'(idx_q) >= 32'(MAX_FRAGS));
  assign seen_bit  = e_seen_q[slot_q][idx_q[FW-1:0]];
  assign bytes_new = e_bytes_q[slot_q] + 32'(flen_q);
  assign complete  = bytes_new >= 32'(e_total_q[slot_q]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frt_pkg::S_IDLE:   if (accept) state_d = opcode_i ? frt_pkg::S_TICK :
                           (early_status != frt_pkg::ST_ACCEPTED) ? frt_pkg::S_OUT :
                           frt_pkg::S_SCAN;
      frt_pkg::S_SCAN:   if (ptr_q == LAST) state_d = frt_pkg::S_DECIDE;
      frt_pkg::S_DECIDE: state_d = (!hit_q && !free_q) ? frt_pkg::S_OUT :
                           frt_pkg::S_UPDATE;
      frt_pkg::S_UPDATE: state_d = frt_pkg::S_OUT;
      frt_pkg::S_TICK:   if (ptr_q == LAST) state_d = frt_pkg::S_OUT;
      frt_pkg::S_OUT:    if (!out_stall_i) state_d = frt_pkg::S_IDLE;
      default:           state_d = frt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    r_status_d = r_status_q;
    unique case (state_q)
      frt_pkg::S_IDLE:   r_status_d = opcode_i ? frt_pkg::ST_TICK_DONE : early_status;
      frt_pkg::S_DECIDE: begin
        if (hit_q && end_q > {9'd0, e_total_q[hit_slot_q]}) begin
          r_status_d = frt_pkg::ST_OOB;
        end else if (!hit_q && !free_q) begin
          r_status_d = frt_pkg::ST_FULL;
        end
      end
      frt_pkg::S_UPDATE: begin
        if (r_status_q == frt_pkg::ST_ACCEPTED) begin
          if (idx_bad) r_status_d = frt_pkg::ST_BAD_INDEX;
          else if (seen_bit) r_status_d = frt_pkg::ST_DUPLICATE;
          else if (complete) r_status_d = frt_pkg::ST_COMPLETED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frt_pkg::S_IDLE;
      max_bytes_q <= frt_pkg::MAX_BYTES_RST;
      timeout_q   <= frt_pkg::TIMEOUT_RST;
      valid_q     <= '0;
      ptr_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      exp_q       <= '0;
      r_status_q  <= frt_pkg::ST_ACCEPTED;
    end else begin
      state_q    <= state_d;
      r_status_q <= r_status_d;
      if (cfg_wr) begin
        if (paddr[2] == frt_pkg::REG_MAX_BYTES[0]) max_bytes_q <= pwdata[23:0];
        else if (paddr[2] == frt_pkg::REG_TIMEOUT[0]) timeout_q <= pwdata[15:0];
      end
      unique case (state_q)
        frt_pkg::S_IDLE: begin
          ptr_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          exp_q  <= '0;
        end
        frt_pkg::S_SCAN: begin
          ptr_q <= ptr_q + SW'(1);
          if (valid_q[ptr_q]) begin
            if (!hit_q && key_eq) hit_q <= 1'b1;
          end else if (!free_q) begin
            free_q <= 1'b1;
          end
        end
        frt_pkg::S_DECIDE: begin
          if (!hit_q && free_q) valid_q[free_slot_q] <= 1'b1;
        end
        frt_pkg::S_UPDATE: begin
          if (r_status_q == frt_pkg::ST_ACCEPTED && !idx_bad && !seen_bit && complete)
            valid_q[slot_q] <= 1'b0;
        end
        frt_pkg::S_TICK: begin
          ptr_q <= ptr_q + SW'(1);
          if (valid_q[ptr_q] && age_inc > {1'b0, timeout_q}) begin
            valid_q[ptr_q] <= 1'b0;
            exp_q <= exp_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      cl_q    <= src_id_i;
      sq_q    <= pkt_seqno_i;
      tot_q   <= total_len_i[23:0];
      off_q   <= byte_offset_i[23:0];
      flen_q  <= frag_len_i;
      nf_q    <= piece_count_i;
      idx_q   <= piece_idx_i;
      pts_q   <= pts_i;
      end_q   <= end_in;
      early_q <= (early_status != frt_pkg::ST_ACCEPTED);
    end
    if (state_q == frt_pkg::S_SCAN) begin
      if (valid_q[ptr_q] && !hit_q && key_eq) hit_slot_q <= ptr_q;
      if (!valid_q[ptr_q] && !free_q) free_slot_q <= ptr_q;
    end
    if (state_q == frt_pkg::S_DECIDE) begin
      slot_q <= hit_q ? hit_slot_q : free_slot_q;
      if (!hit_q && free_q) begin
        e_client_q[free_slot_q] <= cl_q;
        e_seq_q[free_slot_q]    <= sq_q;
        e_total_q[free_slot_q]  <= tot_q;
        e_nfrag_q[free_slot_q]  <= nf_q;
        e_bytes_q[free_slot_q]  <= '0;
        e_stamp_q[free_slot_q]  <= pts_q;
        e_age_q[free_slot_q]    <= '0;
        e_seen_q[free_slot_q]   <= '0;
      end
    end
    if (state_q == frt_pkg::S_UPDATE && r_status_q == frt_pkg::ST_ACCEPTED &&
        !idx_bad && !seen_bit) begin
      e_seen_q[slot_q][idx_q[FW-1:0]] <= 1'b1;
      e_bytes_q[slot_q] <= bytes_new;
      r_plen_q <= e_total_q[slot_q];
      r_pts_q  <= e_stamp_q[slot_q];
    end
    if (state_q == frt_pkg::S_TICK && valid_q[ptr_q] && !(age_inc > {1'b0, timeout_q}))
      e_age_q[ptr_q] <= age_inc[15:0];
    r_off_q <= off_q;
    r_len_q <= flen_q;
  end

  logic stored, done_fr, slot_used;
  logic [4:0] exp_out;
  assign stored  = (r_status_q == frt_pkg::ST_ACCEPTED) || (r_status_q == frt_pkg::ST_COMPLETED);
  assign done_fr = (r_status_q == frt_pkg::ST_COMPLETED);
  assign slot_used = !op_q && !early_q && (r_status_q != frt_pkg::ST_FULL) &&
                     !(r_status_q == frt_pkg::ST_OOB && !hit_q);
  // count saturates at 16 on larger tables
  assign exp_out = (32'(exp_q) > 32'd16) ? 5'd16 : 5'(32'(exp_q));

  assign out_valid_o     = (state_q == frt_pkg::S_OUT);
  assign status_o        = r_status_q;
  assign entry_slot_o    = slot_used ? 4'(32'(hit_q ? hit_slot_q : slot_q)) : 4'd0;
  assign write_offset_o  = stored ? r_off_q : 24'd0;
  assign write_len_o     = stored ? r_len_q : 16'd0;
  assign packet_len_o    = done_fr ? r_plen_q : 24'd0;
  assign packet_pts_o    = done_fr ? r_pts_q : 64'd0;
  assign expired_count_o = op_q ? exp_out : 5'd0;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result changed under stall");
  a_tick_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q |-> status_o == frt_pkg::ST_TICK_DONE)
    else $error("tick gave wrong status");

endmodule
`default_nettype wire

>>> bench/fragment_reassembly_tracker_test.sv
`default_nettype none
module fragment_reassembly_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int FRAG_LIMIT = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] src_id;
    logic [31:0] pkt_seqno;
    logic [31:0] total_len;
    logic [31:0] byte_offset;
    logic [15:0] frag_len;
    logic [15:0] present_len;
    logic [15:0] piece_count;
    logic [15:0] piece_idx;
    logic [63:0] pts;
    logic        client_known;
  } frag_word_t;

  typedef struct packed {
    frt_pkg::status_e status;
    logic [3:0]  entry_slot;
    logic [23:0] write_offset;
    logic [15:0] write_len;
    logic [23:0] packet_len;
    logic [63:0] packet_pts;
    logic [4:0]  expired_count;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  frag_word_t word_q = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] status_o, entry_slot_o;
  logic [23:0] write_offset_o, packet_len_o;
  logic [15:0] write_len_o;
  logic [63:0] packet_pts_o;
  logic [4:0] expired_count_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fragment_reassembly_tracker uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .opcode_i(word_q.opcode), .src_id_i(word_q.src_id),
    .pkt_seqno_i(word_q.pkt_seqno), .total_len_i(word_q.total_len),
    .byte_offset_i(word_q.byte_offset), .frag_len_i(word_q.frag_len),
    .present_len_i(word_q.present_len), .piece_count_i(word_q.piece_count),
    .piece_idx_i(word_q.piece_idx), .pts_i(word_q.pts),
    .client_known_i(word_q.client_known),
    .out_valid_o, .out_stall_i, .status_o, .entry_slot_o, .write_offset_o,
    .write_len_o, .packet_len_o, .packet_pts_o, .expired_count_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [23:0] max_bytes_m;
  logic [15:0] timeout_m;
  logic        slot_valid[SLOTS];
  logic [31:0] slot_client[SLOTS];
  logic [31:0] slot_seq[SLOTS];
  logic [31:0] slot_len[SLOTS];
  logic [15:0] slot_frags[SLOTS];
  logic [31:0] slot_bytes[SLOTS];
  logic [63:0] slot_pts[SLOTS];
  logic [15:0] slot_age[SLOTS];
  logic [63:0] slot_seen[SLOTS];

  verdict_t pending_verdicts[$];
  int errors = 0;
  int idle_cycles = 0;
  int words_sent = 0, verdicts_seen = 0, completions = 0, expiries = 0;
  bit hold_off = 1'b0;
  bit rx_stall_on = 1'b1;

  function automatic verdict_t predict_verdict(frag_word_t w);
    verdict_t v;
    int hit, free_i;
    logic [32:0] reach;
    logic [16:0] aged;
    int gone;
    v = '0;
    if (w.opcode) begin
      gone = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) begin
          aged = slot_age[i] + 17'd1;
          if (aged > timeout_m) begin
            slot_valid[i] = 1'b0;
            gone++;
          end else begin
            slot_age[i] = aged[15:0];
          end
        end
      end
      v.status = frt_pkg::ST_TICK_DONE;
      v.expired_count = 5'(gone);
      return v;
    end
    reach = {1'b0, w.byte_offset} + w.frag_len;
    if (w.total_len == 0 || w.total_len > max_bytes_m) begin
      v.status = frt_pkg::ST_BAD_LEN; return v;
    end
    if (reach > w.total_len) begin
      v.status = frt_pkg::ST_OOB; return v;
    end
    if (w.present_len < w.frag_len) begin
      v.status = frt_pkg::ST_SHORT; return v;
    end
    if (!w.client_known) begin
      v.status = frt_pkg::ST_UNKNOWN; return v;
    end
    hit = -1; free_i = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) begin
        if (hit < 0 && slot_client[i] == w.src_id && slot_seq[i] == w.pkt_seqno)
          hit = i;
      end else if (free_i < 0) begin
        free_i = i;
      end
    end
    if (hit >= 0) begin
      if (reach > slot_len[hit]) begin
        v.status = frt_pkg::ST_OOB; v.entry_slot = 4'(hit); return v;
      end
    end else begin
      if (free_i < 0) begin
        v.status = frt_pkg::ST_FULL; return v;
      end
      hit = free_i;
      slot_valid[hit] = 1'b1;
      slot_client[hit] = w.src_id;
      slot_seq[hit] = w.pkt_seqno;
      slot_len[hit] = w.total_len;
      slot_frags[hit] = w.piece_count;
      slot_bytes[hit] = '0;
      slot_pts[hit] = w.pts;
      slot_age[hit] = '0;
      slot_seen[hit] = '0;
    end
    v.entry_slot = 4'(hit);
    if (w.piece_idx >= slot_frags[hit] || w.piece_idx >= FRAG_LIMIT) begin
      v.status = frt_pkg::ST_BAD_INDEX; return v;
    end
    if (slot_seen[hit][w.piece_idx[5:0]]) begin
      v.status = frt_pkg::ST_DUPLICATE; return v;
    end
    slot_seen[hit][w.piece_idx[5:0]] = 1'b1;
    slot_bytes[hit] = slot_bytes[hit] + w.frag_len;
    v.write_offset = w.byte_offset[23:0];
    v.write_len = w.frag_len;
    if (slot_bytes[hit] >= slot_len[hit]) begin
      slot_valid[hit] = 1'b0;
      v.status = frt_pkg::ST_COMPLETED;
      v.packet_len = slot_len[hit][23:0];
      v.packet_pts = slot_pts[hit];
    end else begin
      v.status = frt_pkg::ST_ACCEPTED;
    end
    return v;
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result word with nothing expected, status %0d", status_o);
          errors++;
        end else begin
          e = pending_verdicts.pop_front();
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++;
          end
          if (entry_slot_o !== e.entry_slot) begin
            $error("entry_slot exp %0d got %0d", e.entry_slot, entry_slot_o); errors++;
          end
          if (write_offset_o !== e.write_offset) begin
            $error("write_offset exp %0h got %0h", e.write_offset, write_offset_o);
            errors++;
          end
          if (write_len_o !== e.write_len) begin
            $error("write_len exp %0h got %0h", e.write_len, write_len_o); errors++;
          end
          if (packet_len_o !== e.packet_len) begin
            $error("packet_len exp %0h got %0h", e.packet_len, packet_len_o); errors++;
          end
          if (packet_pts_o !== e.packet_pts) begin
            $error("packet_pts exp %0h got %0h", e.packet_pts, packet_pts_o); errors++;
          end
          if (expired_count_o !== e.expired_count) begin
            $error("expired_count exp %0d got %0d", e.expired_count, expired_count_o);
            errors++;
          end
          if (e.status == frt_pkg::ST_COMPLETED) completions++;
          expiries += e.expired_count;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_off)
      out_stall_i <= 1'b1;
    else if (!rx_stall_on)
      out_stall_i <= 1'b0;
    else
      out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  int burst_left = 0;

  task automatic send_word(frag_word_t w);
    verdict_t v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 30)) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    word_q <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v = predict_verdict(w);
    pending_verdicts.insert(pending_verdicts.size(), v);
    words_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == 3'(frt_pkg::REG_MAX_BYTES * 4)) max_bytes_m = value[23:0];
    else timeout_m = value[15:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic check_reg(logic [2:0] addr, logic [31:0] want);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0; paddr <= addr; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("prdata exp %0h got %0h", want, prdata); errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_limits(logic [23:0] max_bytes, logic [15:0] timeout);
    drain();
    write_reg(3'(frt_pkg::REG_MAX_BYTES * 4), 32'(max_bytes));
    write_reg(3'(frt_pkg::REG_TIMEOUT * 4), 32'(timeout));
    check_reg(3'(frt_pkg::REG_MAX_BYTES * 4), 32'(max_bytes));
    check_reg(3'(frt_pkg::REG_TIMEOUT * 4), 32'(timeout));
  endtask

  function automatic frag_word_t scrambled_word();
    logic [287:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom};
    return bits[$bits(frag_word_t)-1:0];
  endfunction

  function automatic frag_word_t tick_word();
    frag_word_t w;
    w = scrambled_word();
    w.opcode = 1'b1;
    return w;
  endfunction

  function automatic frag_word_t good_frag(logic [31:0] cl, logic [31:0] sq,
      logic [31:0] total, logic [31:0] off, logic [15:0] flen,
      logic [15:0] nfr, logic [15:0] idx);
    frag_word_t w;
    w.opcode = 1'b0;
    w.src_id = cl; w.pkt_seqno = sq; w.total_len = total;
    w.byte_offset = off; w.frag_len = flen;
    w.present_len = flen + 16'($urandom_range(0, 3));
    if (w.present_len < flen) w.present_len = flen;
    w.piece_count = nfr; w.piece_idx = idx;
    w.pts = {$urandom, $urandom};
    w.client_known = 1'b1;
    return w;
  endfunction

  task automatic test_directed_checks();
    frag_word_t w;
    w = good_frag(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 4, 0);
    send_word(w);                                   // zero length
    w.total_len = 32'hFFFFFFFF; send_word(w);       // over max
    w = good_frag(1, 1, 100, 32'hFFFFFFFF, 16'hFFFF, 4, 0);
    w.total_len = 65536; send_word(w);              // bound without wrap
    w = good_frag(1, 1, 100, 0, 10, 4, 0);
    w.present_len = 9; send_word(w);                // short payload
    w = good_frag(1, 1, 100, 0, 10, 4, 0);
    w.client_known = 1'b0; send_word(w);
    send_word(good_frag(2, 7, 30, 0, 10, 3, 0));
    send_word(good_frag(2, 7, 30, 0, 10, 3, 0));    // duplicate
    send_word(good_frag(2, 7, 60, 25, 10, 3, 1));   // past stored length
    send_word(good_frag(2, 7, 30, 10, 10, 3, 3));   // index >= count
    send_word(good_frag(2, 7, 30, 10, 10, 3, 1));
    send_word(good_frag(2, 7, 30, 20, 10, 3, 2));   // completes
    send_word(good_frag(3, 1, 50, 0, 10, 0, 0));    // zero count, entry stays
    send_word(good_frag(4, 1, 50, 0, 10, 16'hFFFF, 64)); // index past bitmap
    send_word(good_frag(5, 0, 65536, 0, 16'hFFFF, 2, 63));
    send_word(tick_word());
    set_limits(24'd65536, 16'd2000);
  endtask

  task automatic test_table_full_and_aging();
    set_limits(24'hFFFFFF, 16'd3);
    for (int i = 0; i < SLOTS + 2; i++)
      send_word(good_frag(32'(100 + i), 9, 1000, 0, 1, 8, 0));
    repeat (5) send_word(tick_word());
    set_limits(24'hFFFFFF, 16'd0);
    send_word(good_frag(7, 7, 10, 0, 1, 4, 0));
    send_word(tick_word());
    set_limits(24'd0, 16'hFFFF);
    send_word(good_frag(7, 7, 10, 0, 1, 4, 0));
    set_limits(24'd1, 16'd1);
    send_word(good_frag(7, 7, 1, 0, 1, 1, 0));
  endtask

  function automatic frag_word_t random_word(int n_clients);
    frag_word_t w;
    int r;
    logic [15:0] nfr, idx, flen;
    logic [31:0] total;
    r = $urandom_range(0, 99);
    if (r < 8) return tick_word();
    if (r < 20) begin
      w = scrambled_word();
      w.opcode = 1'b0;
      if ($urandom_range(0, 1)) w.total_len = $urandom_range(0, 70000);
      return w;
    end
    nfr = 16'($urandom_range(1, 6));
    idx = 16'($urandom_range(0, nfr - 1));
    if ($urandom_range(0, 19) == 0) idx = 16'($urandom);
    flen = 16'($urandom_range(1, 40));
    total = 32'(nfr) * 40;
    w = good_frag(32'($urandom_range(0, n_clients)) ^ 32'hA5A5_0000,
                  32'($urandom_range(0, 3)), total, 32'(idx) * 40, flen, nfr, idx);
    if ($urandom_range(0, 15) == 0) begin
      w.src_id = $urandom; w.pkt_seqno = $urandom; w.byte_offset = $urandom;
      w.pts = {$urandom, $urandom}; w.frag_len = 16'($urandom);
      w.present_len = 16'hFFFF; w.total_len = $urandom_range(1, 65536);
      w.byte_offset = 0; if (w.frag_len > w.total_len) w.frag_len = 16'(w.total_len);
    end
    if ($urandom_range(0, 30) == 0) w.client_known = 1'b0;
    return w;
  endfunction

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 150) rx_stall_on = 1'b0;
      if (i % 300 == 200) rx_stall_on = 1'b1;
      send_word(random_word(i % 400 < 200 ? 6 : 30));
    end
  endtask

  task automatic test_receiver_hold();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (10) send_word(random_word(6));
    join
  endtask

  initial begin
    max_bytes_m = frt_pkg::MAX_BYTES_RST;
    timeout_m = frt_pkg::TIMEOUT_RST;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_checks();
    test_table_full_and_aging();
    set_limits(24'd65536, 16'd40);
    test_receiver_hold();
    test_random_traffic(450);
    set_limits(24'd200, 16'd5);
    test_random_traffic(450);
    set_limits(24'hFFFFFF, 16'd2000);
    test_random_traffic(450);
    drain();
    $display("sent %0d words, checked %0d results", words_sent, verdicts_seen);
    $display("%0d packets completed, %0d entries timed out", completions, expiries);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
